@@ hw/rtl/window_power_range_query_macros.svh @@
// assertion macros shared by the range query block
`ifndef WINDOW_POWER_RANGE_QUERY_MACROS_SVH
`define WINDOW_POWER_RANGE_QUERY_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define WPRQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wprq same-cycle check failed");

// next-cycle implication, disabled while reset is applied
`define WPRQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wprq next-cycle check failed");

`endif

@@ hw/rtl/wprq_pkg.sv @@
// shared types and constants of the range query block
package wprq_pkg;

	// field widths of the stream words
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 7;
	localparam int POWER_W   = 27;
	localparam int SUM_W     = 28;
	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 32;

	// item kinds carried in s_tuser
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// request from the sequencer to the histogram unit
	typedef struct packed {
		logic go;
		logic leave;
	} hist_req_t;

endpackage

@@ hw/rtl/wprq_elem_mem.sv @@
// element store: one write port, one registered read port
module wprq_elem_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int VW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [VW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [VW-1:0] rdata
);

	logic [VW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/wprq_hist_unit.sv @@
// histogram memory with shared multiply-accumulate for the running sum
module wprq_hist_unit
	import wprq_pkg::*;
#(
	parameter int VALUE_RANGE = 128,
	parameter int ARRAY_DEPTH = 1024,
	parameter int VW          = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  hist_req_t        req,
	input  logic [VW-1:0]    value,
	output logic [SUM_W-1:0] sum
);

	localparam int CW = $clog2(ARRAY_DEPTH + 1);
	localparam int PW = CW + 1 + VW;

	logic [CW-1:0]          mem [VALUE_RANGE];
	logic [VALUE_RANGE-1:0] vld_q;
	logic                   go_s1;
	logic                   leave_s1;
	logic [VW-1:0]          v_s1;
	logic [CW-1:0]          cnt_s1;
	logic                   hit_s1;
	logic [SUM_W-1:0]       sum_q;

	logic [CW-1:0]   cnt;
	logic [CW-1:0]   cnt_new;
	logic [CW:0]     mult_op;
	logic [PW-1:0]   prod;
	logic            skip;

	// stage 1: read the count of this value
	always_ff @(posedge clk) begin
		if (req.go) begin
			cnt_s1   <= mem[value];
			hit_s1   <= vld_q[value];
			v_s1     <= value;
			leave_s1 <= req.leave;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= req.go;
		end
	end

	// stage 2: count change and sum delta, (2c+1)*v on entry, (2c-1)*v on exit
	always_comb begin
		cnt     = hit_s1 ? cnt_s1 : '0;
		skip    = leave_s1 && (cnt == '0);
		mult_op = leave_s1 ? {cnt - CW'(1), 1'b1} : {cnt, 1'b1};
		cnt_new = leave_s1 ? (cnt - CW'(1)) : (cnt + CW'(1));
		prod    = PW'(mult_op) * PW'(v_s1);
	end

	// count write-back
	always_ff @(posedge clk) begin
		if (go_s1 && !skip) begin
			mem[v_s1] <= cnt_new;
		end
	end

	// valid bits and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			sum_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
			sum_q <= '0;
		end else if (go_s1 && !skip) begin
			vld_q[v_s1] <= 1'b1;
			if (leave_s1) begin
				sum_q <= sum_q - SUM_W'(prod);
			end else begin
				sum_q <= sum_q + SUM_W'(prod);
			end
		end
	end

	assign sum = sum_q;

endmodule

@@ hw/rtl/window_power_range_query.sv @@
// top level: range power query over a loaded array with a sliding window
//
// Input stream (s_*): each word is either a load (s_tuser = 0) that writes one
// array element, or a range query (s_tuser = 1). Loads give no output word;
// each query gives exactly one output word on m_*, in query order.
// A load stores the value and empties the window, so the histogram and
// running sum restart at zero.
// A query moves the current window to [left, right] one element at a time.
// Each element moved goes through an element store read, a histogram read,
// and a histogram write-back with one multiply-accumulate into the running
// sum. The answer is ready once every element that enters or leaves the
// window has moved; one word is worked at a time.
// A query with left > right answers in the next cycle with bad_range set and
// a zero sum, and leaves the window alone.
// Reset empties the window, clears the histogram valid bits and the sum at
// once; the element store holds no data until it is loaded.
// A stalled receiver holds the result in the output register; s_tready stays
// low until that word is taken or being taken.
`include "window_power_range_query_macros.svh"

module window_power_range_query
	import wprq_pkg::*;
#(
	parameter int ARRAY_DEPTH = 1024,
	parameter int VALUE_RANGE = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// elem_index [9:0], elem_value [16:10], query_left [26:17], query_right [36:27]
	input  logic [S_DATA_W-1:0] s_tdata,
	// kind [0]
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// power_sum [26:0]
	output logic [M_DATA_W-1:0] m_tdata,
	// bad_range [0]
	output logic [0:0]          m_tuser
);

	localparam int AW = $clog2(ARRAY_DEPTH);
	localparam int EW = $clog2(ARRAY_DEPTH + 1);
	localparam int VW = $clog2(VALUE_RANGE);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ELEM = 2'd1;
	localparam logic [1:0] ST_HIST = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]         state_q;
	logic [AW-1:0]      low_q;
	logic [EW-1:0]      end_q;
	logic [AW-1:0]      left_q;
	logic [EW-1:0]      nend_q;
	logic               leave_q;
	logic               m_tvalid_q;
	logic [POWER_W-1:0] m_sum_q;
	logic               m_bad_q;

	logic [IDX_W-1:0] in_idx;
	logic [VAL_W-1:0] in_val;
	logic [IDX_W-1:0] in_left;
	logic [IDX_W-1:0] in_right;
	logic             accept;
	logic             idx_ok;
	logic [VW-1:0]    val_sat;
	logic [AW-1:0]    left_sat;
	logic [AW-1:0]    right_sat;
	logic             m_set;

	logic [EW-1:0]  low_x;
	logic [EW-1:0]  left_x;
	logic           step;
	logic           step_leave;
	logic [AW-1:0]  pos;
	logic [AW-1:0]  low_d;
	logic [EW-1:0]  end_d;

	logic             elem_we;
	logic [VW-1:0]    elem_rdata;
	logic             hist_clear;
	hist_req_t        hist_req;
	logic [SUM_W-1:0] hist_sum;

	// input word fields
	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_val   = s_tdata[IDX_W+VAL_W-1:IDX_W];
	assign in_left  = s_tdata[2*IDX_W+VAL_W-1:IDX_W+VAL_W];
	assign in_right = s_tdata[3*IDX_W+VAL_W-1:2*IDX_W+VAL_W];

	assign s_tready = (state_q == ST_IDLE) && !(m_tvalid_q && !m_tready);
	assign accept   = s_tvalid && s_tready;

	// range checks and saturation
	always_comb begin
		idx_ok    = 32'(in_idx) < ARRAY_DEPTH;
		val_sat   = (32'(in_val) >= VALUE_RANGE) ? VW'(VALUE_RANGE - 1) : VW'(in_val);
		left_sat  = (32'(in_left) >= ARRAY_DEPTH) ? AW'(ARRAY_DEPTH - 1) : AW'(in_left);
		right_sat = (32'(in_right) >= ARRAY_DEPTH) ? AW'(ARRAY_DEPTH - 1) : AW'(in_right);
	end

	// next window move: grow left, grow right, shrink right, shrink left
	always_comb begin
		low_x      = EW'(low_q);
		left_x     = EW'(left_q);
		step       = 1'b1;
		step_leave = 1'b0;
		pos        = low_q;
		low_d      = low_q;
		end_d      = end_q;
		if (low_x > left_x) begin
			pos   = low_q - AW'(1);
			low_d = low_q - AW'(1);
		end else if (end_q < nend_q) begin
			pos   = AW'(end_q);
			end_d = end_q + EW'(1);
		end else if (end_q > nend_q) begin
			pos        = AW'(end_q - EW'(1));
			end_d      = end_q - EW'(1);
			step_leave = 1'b1;
		end else if (low_x < left_x) begin
			pos        = low_q;
			low_d      = low_q + AW'(1);
			step_leave = 1'b1;
		end else begin
			step = 1'b0;
		end
	end

	assign elem_we        = accept && (s_tuser[0] == KIND_LOAD) && idx_ok;
	assign hist_clear     = elem_we;
	assign hist_req.go    = (state_q == ST_HIST);
	assign hist_req.leave = leave_q;

	// a result word is ready: inverted range at once, or the window has arrived
	assign m_set = (accept && (s_tuser[0] == KIND_QUERY) && (left_sat > right_sat)) ||
		((state_q == ST_ELEM) && !step);

	// sequencer and window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			low_q      <= '0;
			end_q      <= '0;
			left_q     <= '0;
			nend_q     <= '0;
			leave_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser[0] == KIND_LOAD)) begin
						if (idx_ok) begin
							low_q <= '0;
							end_q <= '0;
						end
					end else if (accept) begin
						if (left_sat <= right_sat) begin
							left_q  <= left_sat;
							nend_q  <= EW'(right_sat) + EW'(1);
							state_q <= ST_ELEM;
							if (EW'(low_q) == end_q) begin
								low_q <= left_sat;
								end_q <= EW'(left_sat);
							end
						end
					end
				end
				ST_ELEM: begin
					if (step) begin
						low_q   <= low_d;
						end_q   <= end_d;
						leave_q <= step_leave;
						state_q <= ST_HIST;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_HIST: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_ELEM;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (m_set) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && (s_tuser[0] == KIND_QUERY)) begin
			m_sum_q <= '0;
			m_bad_q <= 1'b1;
		end else if (state_q == ST_ELEM && !step) begin
			m_sum_q <= hist_sum[POWER_W-1:0];
			m_bad_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(m_sum_q);
	assign m_tuser  = m_bad_q;

	wprq_elem_mem #(
		.DEPTH (ARRAY_DEPTH),
		.AW    (AW),
		.VW    (VW)
	) u_elem_mem (
		.clk   (clk),
		.we    (elem_we),
		.waddr (AW'(in_idx)),
		.wdata (val_sat),
		.raddr (pos),
		.rdata (elem_rdata)
	);

	wprq_hist_unit #(
		.VALUE_RANGE (VALUE_RANGE),
		.ARRAY_DEPTH (ARRAY_DEPTH),
		.VW          (VW)
	) u_hist_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (hist_clear),
		.req    (hist_req),
		.value  (elem_rdata),
		.sum    (hist_sum)
	);

	// checks
	`WPRQ_ASSERT_IMP(a_window_order, 1'b1, EW'(low_q) <= end_q)
	`WPRQ_ASSERT_IMP(a_bad_range_zero, m_tvalid && m_tuser[0], m_tdata == '0)
	`WPRQ_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !s_tready)
	`WPRQ_ASSERT_NEXT(a_hist_follows, state_q == ST_HIST, state_q == ST_UPD)

endmodule

@@ sim/tb_window_power_range_query.sv @@
// testbench for the range power query block: self-checking stream stimulus with a window predictor
module tb_window_power_range_query;
	import wprq_pkg::*;

	localparam int DEPTH   = 1024;
	localparam int VALUES  = 128;
	localparam int ITEMS   = 750;
	localparam int SETTLE  = 400;

	typedef struct packed {
		logic [POWER_W-1:0] power_sum;
		logic               bad_range;
	} answer_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// elem_index [9:0], elem_value [16:10], query_left [26:17], query_right [36:27]
	logic [S_DATA_W-1:0] s_tdata  = '0;
	// kind [0]
	logic [0:0]          s_tuser  = KIND_LOAD;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// power_sum [26:0]
	logic [M_DATA_W-1:0] m_tdata;
	// bad_range [0]
	logic [0:0]          m_tuser;

	// predictor state
	logic [VAL_W-1:0] elem_mem [DEPTH];
	logic [10:0]      value_count [VALUES];
	int unsigned      win_lo;
	int unsigned      win_end;
	logic [SUM_W-1:0] power_acc;

	answer_t     pending_answers[$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	bit          send_idle  = 1'b1;
	bit          recv_idle  = 1'b1;
	int          stall_hold = 0;

	window_power_range_query u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// window predictor
	function automatic void count_in(int unsigned v);
		longint unsigned c;
		longint unsigned s;
		c = 64'(value_count[v]);
		s = 64'(power_acc);
		s = s - c * c * v;
		c = (c + 1) & 11'h7FF;
		s = s + c * c * v;
		value_count[v] = c[10:0];
		power_acc = s[SUM_W-1:0];
	endfunction

	function automatic void count_out(int unsigned v);
		longint unsigned c;
		longint unsigned s;
		c = 64'(value_count[v]);
		s = 64'(power_acc);
		if (c == 0) return;
		s = s - c * c * v;
		c = c - 1;
		s = s + c * c * v;
		value_count[v] = c[10:0];
		power_acc = s[SUM_W-1:0];
	endfunction

	function automatic int unsigned stored_value(int unsigned pos);
		if (pos >= DEPTH) return 0;
		return 32'(elem_mem[pos]);
	endfunction

	function automatic void store_element(int unsigned idx, int unsigned val);
		elem_mem[idx] = val[VAL_W-1:0];
		foreach (value_count[i]) value_count[i] = '0;
		win_lo = 0;
		win_end = 0;
		power_acc = '0;
	endfunction

	function automatic answer_t answer_query(int unsigned left, int unsigned right);
		answer_t     res;
		int unsigned new_end;
		res = '0;
		if (left > right) begin
			res.bad_range = 1'b1;
			return res;
		end
		new_end = right + 1;
		// an empty window restarts at the new left bound
		if (win_lo == win_end) begin
			win_lo = left;
			win_end = left;
		end
		// grow to the hull first, then shrink, so counts never go negative
		while (win_lo > left) begin
			win_lo--;
			count_in(stored_value(win_lo));
		end
		while (win_end < new_end) begin
			count_in(stored_value(win_end));
			win_end++;
		end
		while (win_end > new_end) begin
			win_end--;
			count_out(stored_value(win_end));
		end
		while (win_lo < left) begin
			count_out(stored_value(win_lo));
			win_lo++;
		end
		res.power_sum = power_acc[POWER_W-1:0];
		return res;
	endfunction

	// idle lengths: mostly short, a few long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!send_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_value(int unsigned mode);
		case (mode)
			0: return $urandom_range(0, VALUES - 1);
			1: begin
				case ($urandom_range(0, 3))
					0: return 0;
					1: return VALUES - 1;
					2: return 1;
					default: return 64;
				endcase
			end
			2: return $urandom_range(VALUES - 8, VALUES - 1);
			default: return VALUES - 1;
		endcase
	endfunction

	// send one word and record what it should produce
	task automatic send_word(input logic kind, input logic [S_DATA_W-1:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (kind == KIND_QUERY)
			pending_answers.push_back(answer_query(32'(data[26:17]), 32'(data[36:27])));
		else
			store_element(32'(data[9:0]), 32'(data[16:10]));
	endtask

	task automatic send_load(input int unsigned idx, input int unsigned val);
		logic [9:0] junk_l;
		logic [9:0] junk_r;
		junk_l = 10'($urandom_range(0, DEPTH - 1));
		junk_r = 10'($urandom_range(0, DEPTH - 1));
		send_word(KIND_LOAD, {3'b000, junk_r, junk_l, val[VAL_W-1:0], idx[IDX_W-1:0]});
	endtask

	task automatic send_query(input int unsigned left, input int unsigned right);
		logic [9:0] junk_idx;
		logic [6:0] junk_val;
		junk_idx = 10'($urandom_range(0, DEPTH - 1));
		junk_val = 7'($urandom_range(0, VALUES - 1));
		send_word(KIND_QUERY, {3'b000, right[IDX_W-1:0], left[IDX_W-1:0], junk_val, junk_idx});
	endtask

	// hold off the sender until every answer is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
	endtask

	// load a contiguous span, then slide the window around inside it
	task automatic run_span(input int unsigned base, input int unsigned len,
			input int unsigned n_q, input int unsigned val_mode);
		int          lo;
		int          hi;
		int          l;
		int          r;
		int          tmp;
		int unsigned pick;
		for (int k = 0; k < len; k++) send_load(base + k, pick_value(val_mode));
		lo = base;
		hi = base + len - 1;
		l = lo;
		r = hi;
		for (int k = 0; k < n_q; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// stray load anywhere empties the window
				send_load($urandom_range(0, DEPTH - 1), $urandom_range(0, VALUES - 1));
			end else if (pick < 18) begin
				// inverted range, any positions
				tmp = $urandom_range(1, DEPTH - 1);
				send_query(tmp, $urandom_range(0, tmp - 1));
			end else begin
				if (pick < 50) begin
					l = $urandom_range(lo, hi);
					r = $urandom_range(lo, hi);
				end else if (pick < 78) begin
					l = l + int'($urandom_range(0, 6)) - 3;
					r = r + int'($urandom_range(0, 6)) - 3;
					l = (l < lo) ? lo : (l > hi) ? hi : l;
					r = (r < lo) ? lo : (r > hi) ? hi : r;
				end else if (pick < 89) begin
					l = $urandom_range(lo, hi);
					r = l;
				end else begin
					l = lo;
					r = hi;
				end
				if (l > r) begin
					tmp = l;
					l = r;
					r = tmp;
				end
				send_query(l, r);
			end
		end
	endtask

	// extremes of every field and each special case
	task automatic test_corner_cases();
		send_load(0, 0);
		send_load(1, VALUES - 1);
		send_load(2, VALUES - 1);
		send_load(3, VALUES - 1);
		send_load(4, 1);
		send_query(0, 4);
		send_query(1, 3);
		send_query(0, 0);
		send_query(4, 4);
		send_query(3, 1);
		send_query(DEPTH - 1, 0);
		send_query(1, 4);
		send_load(DEPTH - 1, VALUES - 1);
		send_load(DEPTH - 2, 0);
		send_query(DEPTH - 1, DEPTH - 1);
		send_query(DEPTH - 2, DEPTH - 1);
		send_query(DEPTH - 2, DEPTH - 2);
		send_query(DEPTH - 1, DEPTH - 2);
		send_load(512, 64);
		send_query(DEPTH - 2, DEPTH - 1);
	endtask

	// one value many times, large counts, back to back
	task automatic test_repeated_value();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		run_span($urandom_range(0, DEPTH - 48), 48, 30, 3);
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// random spans and window moves with idling on both sides
	task automatic test_random_windows();
		int unsigned len;
		int unsigned base;
		int unsigned r;
		int unsigned phase;
		phase = 0;
		while (items_sent < ITEMS - 10) begin
			r = $urandom_range(0, 99);
			len = (r < 80) ? $urandom_range(2, 16) : (r < 95) ? $urandom_range(17, 32) :
				$urandom_range(33, 48);
			r = $urandom_range(0, 9);
			base = (r == 0) ? 0 : (r == 1) ? DEPTH - len : $urandom_range(0, DEPTH - len);
			// some phases run with no idling at all
			r = $urandom_range(0, 3);
			send_idle = (r != 0);
			recv_idle = (r != 0);
			run_span(base, len, $urandom_range(8, 30), $urandom_range(0, 2));
			phase++;
			if (phase % 4 == 0) wait_drained();
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// receiver: random stalls, mostly short
	always @(posedge clk) begin
		if (!recv_idle) begin
			m_tready <= 1'b1;
			stall_hold = 0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:59]: begin
					m_tready <= 1'b1;
					stall_hold = $urandom_range(0, 4);
				end
				[60:91]: begin
					m_tready <= 1'b0;
					stall_hold = $urandom_range(0, 2);
				end
				default: begin
					m_tready <= 1'b0;
					stall_hold = $urandom_range(10, 40);
				end
			endcase
		end
	end

	// compare each accepted result word with the oldest answer
	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result word, power_sum %0d bad_range %0d",
					$time, m_tdata[POWER_W-1:0], m_tuser[0]);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (m_tdata[POWER_W-1:0] !== want.power_sum) begin
					$display("%0t: power_sum mismatch, expected %0d, got %0d",
						$time, want.power_sum, m_tdata[POWER_W-1:0]);
					mismatches++;
				end
				if (m_tuser[0] !== want.bad_range) begin
					$display("%0t: bad_range mismatch, expected %0d, got %0d",
						$time, want.bad_range, m_tuser[0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		foreach (elem_mem[i]) elem_mem[i] = '0;
		foreach (value_count[i]) value_count[i] = '0;
		win_lo = 0;
		win_end = 0;
		power_acc = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		wait_drained();
		test_repeated_value();
		test_random_windows();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("tb_window_power_range_query passed");
		else
			$display("tb_window_power_range_query failed");
		$finish;
	end

	// run limit
	initial begin
		#20000000;
		$display("tb_window_power_range_query failed");
		$finish;
	end

endmodule
